// ===== rtl/qas_pkg.sv =====
package qas_pkg;

  // Field widths of the character and result items.
  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IndexW = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned LimitW = 6;

  // Default and reset values.
  localparam int unsigned MaxArgumentsDef = 32;
  localparam logic [LimitW-1:0] ArgLimitReset = 6'd32;

  // Result queue depth; must be a power of two, at least two.
  localparam int unsigned ResFifoDepth = 4;
  localparam int unsigned ResPtrW      = $clog2(ResFifoDepth);
  localparam int unsigned ResCntW      = ResPtrW + 1;

  // Special characters.
  localparam logic [CharW-1:0] CharDquote = 8'h22;
  localparam logic [CharW-1:0] CharSquote = 8'h27;
  localparam logic [CharW-1:0] CharBslash = 8'h5C;

  // Result kinds.
  localparam logic [KindW-1:0] KindChar = 2'd0;
  localparam logic [KindW-1:0] KindTerm = 2'd1;
  localparam logic [KindW-1:0] KindLine = 2'd2;

  // Splitter modes.
  typedef enum logic [2:0] {
    MODE_SKIP       = 3'd0,
    MODE_PLAIN      = 3'd1,
    MODE_PLAIN_ESC  = 3'd2,
    MODE_QUOTED     = 3'd3,
    MODE_QUOTED_ESC = 3'd4
  } mode_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             line_end;
  } qas_in_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CharW-1:0]  out_char;
    logic [IndexW-1:0] arg_index;
    logic [CountW-1:0] arg_count;
    logic              last;
  } qas_res_t;

  // Line state carried from item to item.
  typedef struct packed {
    mode_e             mode;
    logic              quote_single;
    logic [CountW-1:0] args_done;
    logic              limit_hit;
  } line_state_t;

  // Space, tab, LF, VT, FF and CR separate arguments.
  function automatic logic is_ws(input logic [CharW-1:0] c);
    is_ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// ===== rtl/quoted_argument_splitter.sv =====
// Results: each accepted input item is registered, then decoded and written into
// the result queue once the queue has room for two result items.
// Throughput: one input item per cycle while the result queue has room for two
// results; the queue drains one result item per cycle while out_ready_i is high,
// so a line end that closes an argument yields two result items.
// Reset: line state cleared, argument limit set to 32, result queue emptied.
module quoted_argument_splitter #(
  parameter int unsigned MaxArguments = qas_pkg::MaxArgumentsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qas_pkg::qas_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qas_pkg::qas_res_t           out_item_o,
  input  logic                        cfg_we_i,
  input  logic [qas_pkg::LimitW-1:0]  cfg_wdata_i
);
  import qas_pkg::*;

  logic [LimitW-1:0] arg_limit_q;
  logic              in_vld_q;
  qas_in_t           in_item_q;
  logic              room2;
  logic              fire;
  qas_res_t [1:0]    step_res;
  logic [1:0]        step_cnt;

  // The registered item is processed once the queue has room for two results.
  assign fire       = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || fire;

  // Argument limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_limit_q <= ArgLimitReset;
    end else if (cfg_we_i) begin
      arg_limit_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  qas_step #(
    .MaxArguments(MaxArguments)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_q),
    .arg_limit_i(arg_limit_q),
    .res_o      (step_res),
    .res_cnt_o  (step_cnt)
  );

  qas_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (fire ? step_cnt : 2'd0),
    .wr_data_i  (step_res),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // A held item that cannot be processed is kept for the next cycle.
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_item_q))
    else $error("pending input item lost");

endmodule

// ===== rtl/qas_step.sv =====
module qas_step #(
  parameter int unsigned MaxArguments = qas_pkg::MaxArgumentsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  qas_pkg::qas_in_t              item_i,
  input  logic [qas_pkg::LimitW-1:0]    arg_limit_i,
  output qas_pkg::qas_res_t [1:0]       res_o,
  output logic [1:0]                    res_cnt_o
);
  import qas_pkg::*;

  localparam logic [7:0] MaxArgs8 = 8'(MaxArguments);

  line_state_t st_q, st_d;

  logic [7:0]        lim;
  logic [CountW-1:0] done_inc;
  logic              c_ws, c_quote, c_bs, c_qc;
  logic              open_arg;
  mode_e             eff_mode;
  logic              do_finish;
  logic              do_char;

  // Effective limit: clamp to the maximum, zero acts like one via the compare.
  assign lim = ({2'b00, arg_limit_i} > MaxArgs8) ? MaxArgs8 : {2'b00, arg_limit_i};
  assign done_inc = st_q.args_done + CountW'(1);

  // Character classes.
  assign c_ws    = is_ws(item_i.ch);
  assign c_quote = (item_i.ch == CharDquote) || (item_i.ch == CharSquote);
  assign c_bs    = (item_i.ch == CharBslash);
  assign c_qc    = item_i.ch == (st_q.quote_single ? CharSquote : CharDquote);
  assign open_arg = (st_q.mode == MODE_PLAIN) || (st_q.mode == MODE_PLAIN_ESC) ||
                    (st_q.mode == MODE_QUOTED) || (st_q.mode == MODE_QUOTED_ESC);

  // Decode what a character item does in the current mode.
  always_comb begin
    eff_mode  = open_arg ? st_q.mode : MODE_SKIP;
    do_finish = 1'b0;
    do_char   = 1'b0;
    if (!item_i.line_end && !st_q.limit_hit) begin
      unique case (eff_mode)
        MODE_SKIP: begin
          // A non-separator, non-quote character starts a plain argument.
          do_char = !c_ws && !c_quote && !c_bs;
        end
        MODE_PLAIN: begin
          do_finish = c_ws && !c_bs;
          do_char   = !c_ws && !c_bs;
        end
        MODE_QUOTED: begin
          do_finish = c_qc;
          do_char   = !c_qc && !c_bs;
        end
        MODE_PLAIN_ESC, MODE_QUOTED_ESC: begin
          do_char = 1'b1;
        end
        default: begin
          do_char = 1'b0;
        end
      endcase
    end
  end

  // Next line state.
  always_comb begin
    st_d = st_q;
    if (item_i.line_end) begin
      st_d.mode         = MODE_SKIP;
      st_d.quote_single = 1'b0;
      st_d.args_done    = '0;
      st_d.limit_hit    = 1'b0;
    end else if (!st_q.limit_hit) begin
      if (do_finish) begin
        st_d.mode      = MODE_SKIP;
        st_d.args_done = done_inc;
        st_d.limit_hit = ({2'b00, done_inc} >= lim);
      end else begin
        unique case (eff_mode)
          MODE_SKIP: begin
            if (c_ws) begin
              st_d.mode = MODE_SKIP;
            end else if (c_quote) begin
              st_d.mode         = MODE_QUOTED;
              st_d.quote_single = (item_i.ch == CharSquote);
            end else if (c_bs) begin
              st_d.mode = MODE_PLAIN_ESC;
            end else begin
              st_d.mode = MODE_PLAIN;
            end
          end
          MODE_PLAIN: begin
            st_d.mode = c_bs ? MODE_PLAIN_ESC : MODE_PLAIN;
          end
          MODE_PLAIN_ESC: begin
            st_d.mode = MODE_PLAIN;
          end
          MODE_QUOTED: begin
            st_d.mode = c_bs ? MODE_QUOTED_ESC : MODE_QUOTED;
          end
          MODE_QUOTED_ESC: begin
            st_d.mode = MODE_QUOTED;
          end
          default: begin
            st_d.mode = MODE_SKIP;
          end
        endcase
      end
    end
  end

  // Result items for this input item.
  always_comb begin
    res_o     = '0;
    res_cnt_o = 2'd0;
    if (item_i.line_end) begin
      if (open_arg) begin
        res_o[0].kind      = KindTerm;
        res_o[0].arg_index = st_q.args_done[IndexW-1:0];
        res_o[1].kind      = KindLine;
        res_o[1].arg_count = done_inc;
        res_o[1].last      = 1'b1;
        res_cnt_o          = 2'd2;
      end else begin
        res_o[0].kind      = KindLine;
        res_o[0].arg_count = st_q.args_done;
        res_o[0].last      = 1'b1;
        res_cnt_o          = 2'd1;
      end
    end else if (do_finish) begin
      res_o[0].kind      = KindTerm;
      res_o[0].arg_index = st_q.args_done[IndexW-1:0];
      res_o[0].last      = 1'b1;
      res_cnt_o          = 2'd1;
    end else if (do_char) begin
      res_o[0].kind      = KindChar;
      res_o[0].out_char  = item_i.ch;
      res_o[0].arg_index = st_q.args_done[IndexW-1:0];
      res_o[0].last      = 1'b1;
      res_cnt_o          = 2'd1;
    end
  end

  // Line state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= MODE_SKIP;
      st_q.quote_single <= 1'b0;
      st_q.args_done    <= '0;
      st_q.limit_hit    <= 1'b0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  // A line end always leaves a clean line state behind.
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.line_end |=> st_q.mode == MODE_SKIP && st_q.args_done == '0 &&
                                  !st_q.limit_hit)
    else $error("line state not cleared after line end");

  // The limit is only reached after at least one finished argument.
  a_limit_has_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.limit_hit |-> st_q.args_done != '0 && st_q.mode == MODE_SKIP)
    else $error("limit set without finished arguments");

  // Two results only come from a line end that closes an argument.
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o == 2'd2 |-> item_i.line_end && open_arg)
    else $error("two results from a character item");

endmodule

// ===== rtl/qas_res_fifo.sv =====
module qas_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 wr_cnt_i,
  input  qas_pkg::qas_res_t [1:0]    wr_data_i,
  output logic                       room2_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output qas_pkg::qas_res_t          out_item_o
);
  import qas_pkg::*;

  qas_res_t           mem_q [ResFifoDepth];
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               rd;

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= ResCntW'(ResFifoDepth - 2));
  assign rd          = out_valid_o && out_ready_i;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + ResPtrW'(rd);
    count_d  = count_q + ResCntW'(wr_cnt_i) - ResCntW'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage: up to two result items are written per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_data_i[0];
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + ResPtrW'(1)] <= wr_data_i[1];
    end
  end

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ResCntW'(ResFifoDepth))
    else $error("result queue overflow");

  // Writes only come when the queue has room for them.
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_i != 2'd0 |-> room2_o)
    else $error("result queue written without room");

endmodule

// ===== tb/tb_quoted_argument_splitter.sv =====
`timescale 1ns / 1ps

module tb_quoted_argument_splitter;
  import qas_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LimitCap   = MaxArgumentsDef;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  qas_in_t                 in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  qas_res_t                out_item_o;
  logic                    cfg_we_i    = 1'b0;
  logic [LimitW-1:0]       cfg_wdata_i = '0;

  quoted_argument_splitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Splitter state as the testbench sees it.
  mode_e             line_mode     = MODE_SKIP;
  logic              quote_single  = 1'b0;
  int                args_seen     = 0;
  logic              limit_reached = 1'b0;
  logic [LimitW-1:0] limit_reg     = ArgLimitReset;

  qas_res_t tokens_due[$];

  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int stall_request    = 0;
  int stall_left       = 0;
  int chars_sent       = 0;
  int lines_sent       = 0;
  int results_checked  = 0;
  int failures         = 0;
  int input_stalls     = 0;
  int cycle_count      = 0;

  function automatic logic separates(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void push_token(input logic [KindW-1:0] kind, input logic [CharW-1:0] c,
                                     input int idx, input int cnt, input logic last);
    qas_res_t r;
    r.kind      = kind;
    r.out_char  = c;
    r.arg_index = idx[IndexW-1:0];
    r.arg_count = cnt[CountW-1:0];
    r.last      = last;
    tokens_due.push_back(r);
  endfunction

  // An argument has ended: emit its terminator and check the limit.
  function automatic void close_argument();
    int lim;
    lim = (limit_reg > LimitCap) ? LimitCap : int'(limit_reg);
    push_token(KindTerm, '0, args_seen, 0, 1'b1);
    args_seen++;
    line_mode = MODE_SKIP;
    if (args_seen >= lim) limit_reached = 1'b1;
  endfunction

  // Expected results of one accepted item, and the state it leaves behind.
  function automatic void split_step(input qas_in_t it);
    logic [CharW-1:0] c;
    logic [CharW-1:0] closer;
    c = it.ch;
    if (it.line_end) begin
      if (line_mode != MODE_SKIP) begin
        push_token(KindTerm, '0, args_seen, 0, 1'b0);
        args_seen++;
      end
      push_token(KindLine, '0, 0, args_seen, 1'b1);
      line_mode     = MODE_SKIP;
      quote_single  = 1'b0;
      args_seen     = 0;
      limit_reached = 1'b0;
      return;
    end
    if (limit_reached) return;
    if (line_mode == MODE_SKIP) begin
      if (separates(c)) return;
      if (c == CharDquote || c == CharSquote) begin
        quote_single = (c == CharSquote);
        line_mode    = MODE_QUOTED;
        return;
      end
      line_mode = MODE_PLAIN;
    end
    case (line_mode)
      MODE_PLAIN: begin
        if (c == CharBslash) line_mode = MODE_PLAIN_ESC;
        else if (separates(c)) close_argument();
        else push_token(KindChar, c, args_seen, 0, 1'b1);
      end
      MODE_PLAIN_ESC: begin
        line_mode = MODE_PLAIN;
        push_token(KindChar, c, args_seen, 0, 1'b1);
      end
      MODE_QUOTED: begin
        closer = quote_single ? CharSquote : CharDquote;
        if (c == CharBslash) line_mode = MODE_QUOTED_ESC;
        else if (c == closer) close_argument();
        else push_token(KindChar, c, args_seen, 0, 1'b1);
      end
      default: begin
        line_mode = MODE_QUOTED;
        push_token(KindChar, c, args_seen, 0, 1'b1);
      end
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // Compare one result item with the oldest expected one.
  task automatic check_token(input qas_res_t got);
    qas_res_t want;
    if (tokens_due.size() == 0) begin
      note_failure($sformatf("unexpected result: kind %0d char %02h index %0d count %0d last %0d",
                             got.kind, got.out_char, got.arg_index, got.arg_count, got.last));
      return;
    end
    want = tokens_due.pop_front();
    results_checked++;
    if (got.kind !== want.kind || got.out_char !== want.out_char ||
        got.arg_index !== want.arg_index || got.arg_count !== want.arg_count ||
        got.last !== want.last) begin
      note_failure($sformatf({"mismatch: expected kind %0d char %02h index %0d count %0d last %0d,",
                              " got kind %0d char %02h index %0d count %0d last %0d"},
                             want.kind, want.out_char, want.arg_index, want.arg_count, want.last,
                             got.kind, got.out_char, got.arg_index, got.arg_count, got.last));
    end
  endtask

  // Result side: check accepted items and drive ready, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_token(out_item_o);
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog and input stall count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (in_valid_i && !in_ready_o) input_stalls++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               tokens_due.size());
      $display("FAIL quoted_argument_splitter");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, then predict its results.
  task automatic send_item(input qas_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    split_step(it);
  endtask

  task automatic send_ch(input logic [CharW-1:0] c);
    qas_in_t it;
    it.ch       = c;
    it.line_end = 1'b0;
    send_item(it);
    chars_sent++;
  endtask

  task automatic send_eol();
    qas_in_t it;
    it.ch       = CharW'($urandom_range(0, 255));
    it.line_end = 1'b1;
    send_item(it);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_ch(s[i]);
  endtask

  // Stop offering items and wait until every expected result has come out.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg   = v;
  endtask

  function automatic logic [CharW-1:0] ws_char();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  // A random byte that starts a plain argument, other than a backslash.
  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255));
    while (separates(c) || c == CharBslash || c == CharDquote || c == CharSquote);
    return c;
  endfunction

  // A well-formed line of random arguments, sometimes left open at the end.
  task automatic send_random_line();
    int nargs;
    int len;
    int style;
    logic [CharW-1:0] closer;
    logic [CharW-1:0] c;
    nargs = ($urandom_range(0, 99) < 6) ? $urandom_range(30, 36) : $urandom_range(0, 6);
    for (int a = 0; a < nargs; a++) begin
      repeat ($urandom_range(0, 2)) send_ch(ws_char());
      style = $urandom_range(0, 9);
      len   = (nargs > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      if (style < 6) begin
        send_ch(plain_char());
        for (int i = 1; i < len; i++) begin
          case ($urandom_range(0, 9))
            0: begin
              send_ch(CharBslash);
              send_ch(CharW'($urandom_range(0, 255)));
            end
            1:       send_ch($urandom_range(0, 1) ? CharSquote : CharDquote);
            default: send_ch(plain_char());
          endcase
        end
        if (a < nargs - 1 || $urandom_range(0, 1)) send_ch(ws_char());
      end else begin
        closer = $urandom_range(0, 1) ? CharSquote : CharDquote;
        send_ch(closer);
        if (style != 9) begin
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_ch(CharBslash);
              send_ch(CharW'($urandom_range(0, 255)));
            end else begin
              do c = CharW'($urandom_range(0, 255));
              while (c == closer || c == CharBslash);
              send_ch(c);
            end
          end
        end
        if (a < nargs - 1 || $urandom_range(0, 9) != 0) send_ch(closer);
      end
    end
    if ($urandom_range(0, 19) == 0) send_ch(CharBslash);
    send_eol();
  endtask

  // Whitespace of every kind, byte extremes, quotes, escapes and open arguments at line end.
  task automatic test_directed_cases();
    logic [CharW-1:0] seq[];
    seq = '{8'h61, 8'h00, 8'hFF, CharDquote, CharBslash, 8'h20, 8'h09, 8'h0A, 8'h0B,
            8'h0C, 8'h0D, 8'h08, 8'h0E, 8'h20, CharSquote, CharDquote, CharBslash,
            CharSquote, CharSquote, CharDquote, CharDquote, CharDquote, 8'h78};
    foreach (seq[i]) send_ch(seq[i]);
    send_eol();
    send_ch(CharBslash);
    send_eol();
    send_eol();
  endtask

  // Argument limit at zero, one, two and above the maximum.
  task automatic test_arg_limits();
    write_limit(6'd1);
    send_text("ab cd");
    send_eol();
    write_limit(6'd0);
    send_text("ab 'q' r");
    send_eol();
    write_limit(6'd2);
    send_text("x 'y z' w v");
    send_eol();
    write_limit(6'd63);
    for (int i = 0; i < 34; i++) begin
      send_ch(8'(8'h41 + i));
      send_ch(8'h20);
    end
    send_eol();
  endtask

  // Long output hold-off while items keep coming, so the block backs up.
  task automatic test_output_stall();
    write_limit(6'd32);
    stall_request = 60;
    for (int i = 0; i < 40; i++) send_ch(8'(8'h30 + i));
    send_eol();
  endtask

  task automatic test_random_lines(input int target);
    int start;
    start = chars_sent + lines_sent;
    while (chars_sent + lines_sent - start < target) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(0, 12)) send_ch(CharW'($urandom_range(0, 255)));
        send_eol();
      end else begin
        send_random_line();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 46;
    test_directed_cases();
    test_arg_limits();
    write_limit(LimitW'($urandom_range(1, 6)));
    test_random_lines(260);

    send_idle_pct = 46;
    recv_idle_pct = 13;
    write_limit(LimitW'($urandom_range(33, 62)));
    test_random_lines(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    write_limit(LimitW'($urandom_range(1, 31)));
    test_random_lines(120);
    write_limit(6'd32);
    test_random_lines(120);

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (tokens_due.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", tokens_due.size()));

    $display("Sent %0d characters in %0d lines, checked %0d results, %0d input stall cycles.",
             chars_sent, lines_sent, results_checked, input_stalls);
    $display("Limits 0 to 63 written; %0d failures.", failures);
    if (failures == 0) begin
      $display("PASS quoted_argument_splitter");
    end else begin
      $display("FAIL quoted_argument_splitter");
    end
    $finish;
  end

endmodule
